// ----- hdl/stl_pkg.sv -----
`timescale 1ns / 1ps
package stl_pkg;

  localparam int KeywordChars = 9;
  localparam int NumKeywords = 50;
  localparam logic [15:0] PosLimit = 16'hFFFF;
  localparam logic [15:0] LenLimit = 16'hFFFF;

  // Token kinds.
  localparam logic [6:0] K_IDENT  = 7'd0;
  localparam logic [6:0] K_INT    = 7'd1;
  localparam logic [6:0] K_FLOAT  = 7'd2;
  localparam logic [6:0] K_STRING = 7'd3;
  localparam logic [6:0] K_BAD    = 7'd4;
  localparam logic [6:0] K_LPAREN = 7'd5;
  localparam logic [6:0] K_RPAREN = 7'd6;
  localparam logic [6:0] K_COMMA  = 7'd7;
  localparam logic [6:0] K_EQ     = 7'd8;
  localparam logic [6:0] K_LT     = 7'd9;
  localparam logic [6:0] K_LE     = 7'd10;
  localparam logic [6:0] K_NE     = 7'd11;
  localparam logic [6:0] K_GT     = 7'd12;
  localparam logic [6:0] K_GE     = 7'd13;
  localparam logic [6:0] K_PLUS   = 7'd14;
  localparam logic [6:0] K_MINUS  = 7'd15;
  localparam logic [6:0] K_STAR   = 7'd16;
  localparam logic [6:0] K_SLASH  = 7'd17;
  localparam logic [6:0] K_SEMI   = 7'd18;
  localparam logic [6:0] K_KEYWORD0 = 7'd19;

  typedef enum logic [8:0] {
    M_IDLE    = 9'b000000001,
    M_LT      = 9'b000000010,
    M_GT      = 9'b000000100,
    M_SLASH   = 9'b000001000,
    M_COMMENT = 9'b000010000,
    M_NUMBER  = 9'b000100000,
    M_STRING  = 9'b001000000,
    M_WORD    = 9'b010000000,
    M_ERROR   = 9'b100000000
  } lex_mode_t;

  typedef logic [KeywordChars-1:0][7:0] word_t;

  // One emitted token.
  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
  } token_t;

  // Keyword text, zero padded, with its length.
  typedef struct packed {
    logic [3:0] len;
    word_t      text;
  } keyword_t;

  function automatic keyword_t kw(input string s);
    keyword_t k;
    k = '0;
    k.len = 4'(s.len());
    for (int i = 0; i < KeywordChars; i++) begin
      if (i < s.len()) k.text[i] = s[i];
    end
    return k;
  endfunction

  function automatic keyword_t keyword_entry(input logic [5:0] idx);
    keyword_t k;
    case (idx)
      6'd0: k = kw("and");       6'd1: k = kw("avg");
      6'd2: k = kw("begin");     6'd3: k = kw("bool");
      6'd4: k = kw("by");        6'd5: k = kw("close");
      6'd6: k = kw("commit");    6'd7: k = kw("count");
      6'd8: k = kw("create");    6'd9: k = kw("connect");
      6'd10: k = kw("drop");     6'd11: k = kw("desc");
      6'd12: k = kw("delete");   6'd13: k = kw("describe");
      6'd14: k = kw("database"); 6'd15: k = kw("databases");
      6'd16: k = kw("distinct"); 6'd17: k = kw("exit");
      6'd18: k = kw("exists");   6'd19: k = kw("float");
      6'd20: k = kw("false");    6'd21: k = kw("from");
      6'd22: k = kw("group");    6'd23: k = kw("having");
      6'd24: k = kw("int");      6'd25: k = kw("into");
      6'd26: k = kw("insert");   6'd27: k = kw("if");
      6'd28: k = kw("is");       6'd29: k = kw("key");
      6'd30: k = kw("limit");    6'd31: k = kw("max");
      6'd32: k = kw("min");      6'd33: k = kw("null");
      6'd34: k = kw("not");      6'd35: k = kw("open");
      6'd36: k = kw("or");       6'd37: k = kw("order");
      6'd38: k = kw("rollback"); 6'd39: k = kw("string");
      6'd40: k = kw("select");   6'd41: k = kw("set");
      6'd42: k = kw("sum");      6'd43: k = kw("show");
      6'd44: k = kw("true");     6'd45: k = kw("table");
      6'd46: k = kw("tables");   6'd47: k = kw("update");
      6'd48: k = kw("values");   6'd49: k = kw("where");
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ----- hdl/sql_token_lexer.sv -----
`timescale 1ns / 1ps
// Streaming SQL token lexer.
// Input channel: in_valid/in_ready carry one text byte per beat, or an
// end_of_text beat that flushes the pending token and restarts offsets at 0.
// Output channel: out_valid/out_ready carry one token per beat with its
// kind, start offset, length and a last_of_run flag marking the final
// token caused by one input beat. A beat causes zero, one or two tokens.
// Each input byte is registered, lexed combinationally, and its tokens
// enter a four-entry output queue that drives the output channel.
// Throughput is one input beat per cycle while in_ready is high; the queue's
// two-token reserve sets in_ready, so that a beat that makes two tokens
// always finds room for both.
// Reset clears the lexer mode, position counters and the queue, not the word buffer.
// When the receiver stalls, the queue fills and in_ready drops; no token
// is lost and the payload holds until taken.
module sql_token_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  token_kind,
  output logic [15:0] start_offset,
  output logic [15:0] token_length,
  output logic        last_of_run
);
  // Input register.
  logic       s_valid;
  logic [7:0] b;
  logic       s_end;
  logic       room;

  // Accept only when the queue can absorb the registered beat plus this one.
  assign in_ready = room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= in_valid && in_ready;
    end
  end
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      b <= text_byte;
      s_end <= end_of_text;
    end
  end

  // Lexer state.
  stl_pkg::lex_mode_t mode, mode_next;
  logic [15:0] pos, pos_next;
  logic [15:0] tstart, tstart_next;
  logic [15:0] tlen, tlen_next;
  logic        dot, dot_next;
  stl_pkg::word_t word, word_next;
  logic [6:0] wkind;

  stl_keyword_match u_match (.word(word), .len(tlen), .kind(wkind));

  logic is_letter, is_digit, is_space;
  logic [15:0] pos_inc, len_inc;
  logic e0, e1;
  stl_pkg::token_t t0, t1;
  logic need_idle;
  stl_pkg::token_t it;
  logic ie;
  stl_pkg::lex_mode_t imode;
  logic [15:0] istart;
  logic [15:0] ilen;
  logic idot;
  logic iword;

  assign is_letter = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  assign is_digit = b >= "0" && b <= "9";
  assign is_space = b == " " || b == 8'h09 || b == 8'h0A;
  assign pos_inc = (pos == stl_pkg::PosLimit) ? pos : pos + 16'd1;
  assign len_inc = (tlen == stl_pkg::LenLimit) ? tlen : tlen + 16'd1;

  // Idle-mode lexing of the current byte.
  always_comb begin
    ie = 1'b0;
    it = '{kind: stl_pkg::K_IDENT, start: pos, len: 16'd1};
    imode = stl_pkg::M_IDLE;
    istart = tstart;
    ilen = tlen;
    idot = dot;
    iword = 1'b0;
    if (!is_space) begin
      case (b)
        "(": begin ie = 1'b1; it.kind = stl_pkg::K_LPAREN; end
        ")": begin ie = 1'b1; it.kind = stl_pkg::K_RPAREN; end
        ",": begin ie = 1'b1; it.kind = stl_pkg::K_COMMA; end
        "=": begin ie = 1'b1; it.kind = stl_pkg::K_EQ; end
        "+": begin ie = 1'b1; it.kind = stl_pkg::K_PLUS; end
        "-": begin ie = 1'b1; it.kind = stl_pkg::K_MINUS; end
        "*": begin ie = 1'b1; it.kind = stl_pkg::K_STAR; end
        ";": begin ie = 1'b1; it.kind = stl_pkg::K_SEMI; end
        "<": begin imode = stl_pkg::M_LT; istart = pos; ilen = 16'd1; end
        ">": begin imode = stl_pkg::M_GT; istart = pos; ilen = 16'd1; end
        "/": begin imode = stl_pkg::M_SLASH; istart = pos; ilen = 16'd1; end
        "\"": begin imode = stl_pkg::M_STRING; istart = pos_inc; ilen = 16'd0; end
        default: begin
          istart = pos;
          ilen = 16'd1;
          if (is_digit || b == ".") begin
            imode = stl_pkg::M_NUMBER;
            idot = (b == ".");
          end else if (is_letter || b == "_") begin
            imode = stl_pkg::M_WORD;
            iword = 1'b1;
          end else begin
            imode = stl_pkg::M_ERROR;
          end
        end
      endcase
    end
  end

  // Mode transition and token selection.
  always_comb begin
    mode_next = mode;
    pos_next = pos;
    tstart_next = tstart;
    tlen_next = tlen;
    dot_next = dot;
    word_next = word;
    e0 = 1'b0;
    e1 = 1'b0;
    t0 = '{kind: stl_pkg::K_IDENT, start: tstart, len: tlen};
    t1 = it;
    need_idle = 1'b0;
    if (s_end) begin
      mode_next = stl_pkg::M_IDLE;
      pos_next = '0;
      tstart_next = '0;
      tlen_next = '0;
      dot_next = 1'b0;
      case (mode)
        stl_pkg::M_LT: begin e0 = 1'b1; t0.kind = stl_pkg::K_LT; t0.len = 16'd1; end
        stl_pkg::M_GT: begin e0 = 1'b1; t0.kind = stl_pkg::K_GT; t0.len = 16'd1; end
        stl_pkg::M_SLASH: begin e0 = 1'b1; t0.kind = stl_pkg::K_SLASH; t0.len = 16'd1; end
        stl_pkg::M_NUMBER: begin
          e0 = 1'b1;
          t0.kind = dot ? stl_pkg::K_FLOAT : stl_pkg::K_INT;
        end
        stl_pkg::M_STRING: begin e0 = 1'b1; t0.kind = stl_pkg::K_STRING; end
        stl_pkg::M_WORD: begin e0 = 1'b1; t0.kind = wkind; end
        stl_pkg::M_ERROR: begin e0 = 1'b1; t0.kind = stl_pkg::K_BAD; end
        default: ;
      endcase
    end else begin
      pos_next = pos_inc;
      case (mode)
        stl_pkg::M_LT: begin
          e0 = 1'b1;
          if (b == "=") begin
            t0.kind = stl_pkg::K_LE; t0.len = 16'd2; mode_next = stl_pkg::M_IDLE;
          end else if (b == ">") begin
            t0.kind = stl_pkg::K_NE; t0.len = 16'd2; mode_next = stl_pkg::M_IDLE;
          end else begin
            t0.kind = stl_pkg::K_LT; t0.len = 16'd1; need_idle = 1'b1;
          end
        end
        stl_pkg::M_GT: begin
          e0 = 1'b1;
          if (b == "=") begin
            t0.kind = stl_pkg::K_GE; t0.len = 16'd2; mode_next = stl_pkg::M_IDLE;
          end else begin
            t0.kind = stl_pkg::K_GT; t0.len = 16'd1; need_idle = 1'b1;
          end
        end
        stl_pkg::M_SLASH: begin
          if (b == "/") begin
            mode_next = stl_pkg::M_COMMENT;
          end else begin
            e0 = 1'b1; t0.kind = stl_pkg::K_SLASH; t0.len = 16'd1; need_idle = 1'b1;
          end
        end
        stl_pkg::M_COMMENT: begin
          if (b == 8'h0A) mode_next = stl_pkg::M_IDLE;
        end
        stl_pkg::M_NUMBER: begin
          if (is_digit || b == "." || b == "e" || b == "-") begin
            tlen_next = len_inc;
            if (b == ".") dot_next = 1'b1;
          end else begin
            e0 = 1'b1;
            t0.kind = dot ? stl_pkg::K_FLOAT : stl_pkg::K_INT;
            need_idle = 1'b1;
          end
        end
        stl_pkg::M_STRING: begin
          if (b == "\"") begin
            e0 = 1'b1; t0.kind = stl_pkg::K_STRING; mode_next = stl_pkg::M_IDLE;
          end else begin
            tlen_next = len_inc;
          end
        end
        stl_pkg::M_WORD: begin
          if (is_letter || is_digit || b == "_") begin
            if (tlen < 16'(stl_pkg::KeywordChars)) word_next[tlen[3:0]] = b;
            tlen_next = len_inc;
          end else begin
            e0 = 1'b1; t0.kind = wkind; need_idle = 1'b1;
          end
        end
        stl_pkg::M_ERROR: begin
          if (is_space || b == ";") begin
            e0 = 1'b1; t0.kind = stl_pkg::K_BAD; need_idle = 1'b1;
          end else begin
            tlen_next = len_inc;
          end
        end
        default: need_idle = 1'b1;
      endcase
      if (need_idle) begin
        mode_next = imode;
        tstart_next = istart;
        tlen_next = ilen;
        dot_next = idot;
        if (iword) word_next[0] = b;
        e1 = ie;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stl_pkg::M_IDLE;
      pos <= '0;
      tstart <= '0;
      tlen <= '0;
      dot <= 1'b0;
    end else if (s_valid) begin
      mode <= mode_next;
      pos <= pos_next;
      tstart <= tstart_next;
      tlen <= tlen_next;
      dot <= dot_next;
    end
  end
  always_ff @(posedge clk) begin
    if (s_valid) word <= word_next;
  end

  // Pack emitted tokens into the queue, first token first.
  logic p0, p1, l0;
  stl_pkg::token_t q0;
  stl_pkg::token_t qo;
  assign p0 = s_valid && (e0 || e1);
  assign p1 = s_valid && e0 && e1;
  assign q0 = e0 ? t0 : t1;
  assign l0 = !(e0 && e1);

  stl_out_queue u_queue (
    .clk(clk), .rst(rst),
    .push0(p0), .tok0(q0), .last0(l0),
    .push1(p1), .tok1(t1),
    .room(room),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_tok(qo), .out_last(last_of_run)
  );
  assign token_kind = qo.kind;
  assign start_offset = qo.start;
  assign token_length = qo.len;
endmodule

// ----- hdl/stl_keyword_match.sv -----
`timescale 1ns / 1ps
// Parallel compare of the current word against every keyword.
module stl_keyword_match (
  input  stl_pkg::word_t word,
  input  logic [15:0]    len,
  output logic [6:0]     kind
);
  stl_pkg::keyword_t k;
  logic hit;
  always_comb begin
    kind = stl_pkg::K_IDENT;
    k = '0;
    hit = 1'b0;
    for (int i = stl_pkg::NumKeywords - 1; i >= 0; i--) begin
      k = stl_pkg::keyword_entry(6'(i));
      hit = (len == 16'(k.len));
      for (int j = 0; j < stl_pkg::KeywordChars; j++) begin
        if (j < k.len && word[j] != k.text[j]) hit = 1'b0;
      end
      if (hit) kind = 7'(stl_pkg::K_KEYWORD0 + 7'(i));
    end
  end
endmodule

// ----- hdl/stl_out_queue.sv -----
`timescale 1ns / 1ps
// Four-entry token queue between the lexer and the output channel.
module stl_out_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push0,
  input  stl_pkg::token_t tok0,
  input  logic           last0,
  input  logic           push1,
  input  stl_pkg::token_t tok1,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output stl_pkg::token_t out_tok,
  output logic           out_last
);
  typedef struct packed {
    stl_pkg::token_t tok;
    logic            last;
  } entry_t;

  entry_t mem [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] count;
  logic pop;
  logic [1:0] n_push;
  logic [2:0] fill_next;

  assign pop = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_tok = mem[rd_ptr].tok;
  assign out_last = mem[rd_ptr].last;
  assign n_push = {1'b0, push0} + {1'b0, push1};
  // A beat taken now pushes up to two tokens next cycle, after this
  // cycle's pushes have landed, so two slots must stay free beyond them.
  assign fill_next = count + {1'b0, n_push};
  assign room = (fill_next <= 3'd2);

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push0) mem[wr_ptr] <= '{tok: tok0, last: last0};
    if (push1) mem[wr_ptr + 2'd1] <= '{tok: tok1, last: 1'b1};
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(n_push) - 3'(pop);
    end
  end
endmodule
